/* design/mrar_pkg.sv */
// Shared types, codes and defaults of the mouse report router.
package mrar_pkg;

    // Action codes carried on the input channel
    localparam logic [1:0] ACT_REPORT  = 2'd0;
    localparam logic [1:0] ACT_UNMOUNT = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_READY   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_OWNS   = 3'd0;
    localparam logic [2:0] REG_SCALEX = 3'd1;
    localparam logic [2:0] REG_SCALEY = 3'd2;
    localparam logic [2:0] REG_PMIN   = 3'd3;
    localparam logic [2:0] REG_PMAX   = 3'd4;
    localparam logic [2:0] REG_CENTER = 3'd5;

    // Register reset values
    localparam logic        OWNS_RST   = 1'b1;
    localparam logic [10:0] SCALE_RST  = 11'd16;
    localparam logic [15:0] PMIN_RST   = 16'd0;
    localparam logic [15:0] PMAX_RST   = 16'd32767;
    localparam logic [15:0] CENTER_RST = 16'd16384;

    // Report length thresholds
    localparam logic [6:0] LEN_MIN   = 7'd3;
    localparam logic [6:0] LEN_WHEEL = 7'd4;

    localparam int RING_DEPTH_DEF = 8;

    // Live configuration seen by the back end
    typedef struct packed {
        logic        owns;
        logic [10:0] scale_x;
        logic [10:0] scale_y;
        logic [15:0] pmin;
        logic [15:0] pmax;
    } t_cfg;

    // Classified command held in the queue
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        buttons;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] wheel;
        logic              local_route;
    } t_cmd;

    // Absolute report, also the ring entry format
    typedef struct packed {
        logic [7:0]        buttons;
        logic [15:0]       x;
        logic [15:0]       y;
        logic signed [7:0] wheel;
    } t_rep;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

/* design/mrar_cfg.sv */
// Configuration register bank of the mouse report router.
module mrar_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output mrar_pkg::t_cfg    o_cfg
);
    import mrar_pkg::*;

    logic        r_owns,    n_owns;
    logic [10:0] r_scale_x, n_scale_x;
    logic [10:0] r_scale_y, n_scale_y;
    logic [15:0] r_pmin,    n_pmin;
    logic [15:0] r_pmax,    n_pmax;

    assign o_cfg_ready = 1'b1;

    // Decode a write beat; the centre only matters at reset, which loads its default
    always_comb begin
        n_owns    = r_owns;
        n_scale_x = r_scale_x;
        n_scale_y = r_scale_y;
        n_pmin    = r_pmin;
        n_pmax    = r_pmax;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OWNS:   n_owns    = i_cfg_data[0];
                REG_SCALEX: n_scale_x = i_cfg_data[10:0];
                REG_SCALEY: n_scale_y = i_cfg_data[10:0];
                REG_PMIN:   n_pmin    = i_cfg_data;
                REG_PMAX:   n_pmax    = i_cfg_data;
                REG_CENTER: n_owns    = r_owns;
                default:    n_owns    = r_owns;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owns    <= OWNS_RST;
            r_scale_x <= SCALE_RST;
            r_scale_y <= SCALE_RST;
            r_pmin    <= PMIN_RST;
            r_pmax    <= PMAX_RST;
        end else begin
            r_owns    <= n_owns;
            r_scale_x <= n_scale_x;
            r_scale_y <= n_scale_y;
            r_pmin    <= n_pmin;
            r_pmax    <= n_pmax;
        end
    end

    assign o_cfg.owns    = r_owns;
    assign o_cfg.scale_x = r_scale_x;
    assign o_cfg.scale_y = r_scale_y;
    assign o_cfg.pmin    = r_pmin;
    assign o_cfg.pmax    = r_pmax;

endmodule

/* design/mrar_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
module mrar_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_buttons,
    input  logic signed [7:0]  i_delta_x,
    input  logic signed [7:0]  i_delta_y,
    input  logic signed [7:0]  i_wheel_delta,
    input  logic [6:0]         i_report_length,
    input  logic               i_route_local,
    input  logic               i_pop,
    output mrar_pkg::t_qhead   o_head
);
    import mrar_pkg::*;

    t_cmd       cmd;
    logic       keep;
    logic       push;
    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    // Classify the beat; short reports are dropped here
    always_comb begin
        cmd.kind        = i_action;
        cmd.buttons     = 8'd0;
        cmd.dx          = 8'sd0;
        cmd.dy          = 8'sd0;
        cmd.wheel       = 8'sd0;
        cmd.local_route = i_route_local;
        keep            = 1'b1;
        unique case (i_action)
            ACT_REPORT: begin
                cmd.buttons = i_buttons;
                cmd.dx      = i_delta_x;
                cmd.dy      = i_delta_y;
                cmd.wheel   = (i_report_length >= LEN_WHEEL) ? i_wheel_delta : 8'sd0;
                keep        = (i_report_length >= LEN_MIN);
            end
            ACT_UNMOUNT: keep = 1'b1;
            ACT_RELEASE: keep = 1'b1;
            ACT_READY:   keep = 1'b1;
            default:     keep = 1'b1;
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall && keep;

    // Advance the two-entry queue pointers
    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

/* design/mrar_back.sv */
// Back end: position update, suppression, local ring and output register.
module mrar_back #(
    parameter int RING_DEPTH = mrar_pkg::RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrar_pkg::t_cfg     i_cfg,
    input  mrar_pkg::t_qhead   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_destination,
    output logic [7:0]         o_out_buttons,
    output logic [15:0]        o_abs_x,
    output logic [15:0]        o_abs_y,
    output logic signed [7:0]  o_out_wheel
);
    import mrar_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    // Lower bound first, upper bound second, as the bounds may be inverted
    function automatic logic [15:0] clamp(input logic signed [21:0] v,
                                          input logic [15:0] lo,
                                          input logic [15:0] hi);
        logic [15:0] res;
        if (v < $signed({6'd0, lo})) begin
            res = lo;
        end else if (v > $signed({6'd0, hi})) begin
            res = hi;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    t_cmd cmd;
    logic is_rep, is_unm, is_rel, is_rdy;
    logic idle_rep, do_proc, dup, may_emit, out_free, go;
    logic emit_proc, emit_rdy, push, ring_full;
    logic signed [19:0] prod_x, prod_y;
    logic signed [21:0] sum_x, sum_y;
    logic [15:0] new_x, new_y;
    t_rep proc_rep, rel_rep, push_rep;

    logic [15:0]      r_pos_x, n_pos_x;
    logic [15:0]      r_pos_y, n_pos_y;
    logic [7:0]       r_held,  n_held;
    t_rep             r_last,  n_last;
    logic             r_last_valid, n_last_valid;
    logic [PTR_W-1:0] r_head,  n_head;
    logic [PTR_W-1:0] r_tail,  n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             we;
    logic [PTR_W-1:0] wa;
    t_rep             r_ring [RING_DEPTH];
    t_rep             r_head_q;
    logic             r_out_valid, n_out_valid;
    logic             r_dest;
    t_rep             r_out;

    assign cmd    = i_head.cmd;
    assign is_rep = (cmd.kind == ACT_REPORT);
    assign is_unm = (cmd.kind == ACT_UNMOUNT);
    assign is_rel = (cmd.kind == ACT_RELEASE);
    assign is_rdy = (cmd.kind == ACT_READY);

    // Take the head only when a possible result has room
    assign may_emit = is_rdy || ((is_rep || is_unm) && !cmd.local_route);
    assign out_free = !r_out_valid || !i_out_stall;
    assign go       = i_head.valid && (!may_emit || out_free);
    assign o_pop    = go;

    // Drop idle repeats, and reports and unmounts when not the owner
    assign idle_rep = is_rep && (cmd.dx == 8'sd0) && (cmd.dy == 8'sd0)
                      && (cmd.wheel == 8'sd0) && (cmd.buttons == r_held);
    assign do_proc  = ((is_rep && !idle_rep) || is_unm) && i_cfg.owns;

    // Scale, accumulate and clamp the position
    assign prod_x = cmd.dx * $signed({1'b0, i_cfg.scale_x});
    assign prod_y = cmd.dy * $signed({1'b0, i_cfg.scale_y});
    assign sum_x  = $signed({6'd0, r_pos_x}) + $signed({{2{prod_x[19]}}, prod_x});
    assign sum_y  = $signed({6'd0, r_pos_y}) + $signed({{2{prod_y[19]}}, prod_y});
    assign new_x  = clamp(sum_x, i_cfg.pmin, i_cfg.pmax);
    assign new_y  = clamp(sum_y, i_cfg.pmin, i_cfg.pmax);

    // Build the outgoing and release reports from the clamped positions
    always_comb begin
        proc_rep.buttons = cmd.buttons;
        proc_rep.x       = clamp($signed({6'd0, new_x}), i_cfg.pmin, i_cfg.pmax);
        proc_rep.y       = clamp($signed({6'd0, new_y}), i_cfg.pmin, i_cfg.pmax);
        proc_rep.wheel   = cmd.wheel;
        rel_rep.buttons  = 8'd0;
        rel_rep.x        = clamp($signed({6'd0, r_pos_x}), i_cfg.pmin, i_cfg.pmax);
        rel_rep.y        = clamp($signed({6'd0, r_pos_y}), i_cfg.pmin, i_cfg.pmax);
        rel_rep.wheel    = 8'sd0;
    end

    assign dup       = r_last_valid && (proc_rep == r_last);
    assign emit_proc = go && do_proc && !dup && !cmd.local_route;
    assign emit_rdy  = go && is_rdy && (r_count != '0);
    assign push      = go && (is_rel || (do_proc && !dup && cmd.local_route));
    assign push_rep  = is_rel ? rel_rep : proc_rep;
    assign ring_full = (r_count == CNT_FULL);

    // Work out the next state of position, memory and ring pointers
    always_comb begin
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_held       = r_held;
        n_last       = r_last;
        n_last_valid = r_last_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        we           = 1'b0;
        wa           = r_tail;
        if (go) begin
            if (is_unm || is_rel) begin
                n_held = 8'd0;
            end
            if (is_rel) begin
                n_last_valid = 1'b0;
            end
            if (do_proc) begin
                n_pos_x = new_x;
                n_pos_y = new_y;
                n_held  = cmd.buttons;
                if (!dup) begin
                    n_last       = proc_rep;
                    n_last_valid = 1'b1;
                end
            end
        end
        // Push: when full, zero buttons overwrite the head, else drop the oldest
        if (push) begin
            we = 1'b1;
            if (ring_full && (push_rep.buttons == 8'd0)) begin
                wa = r_head;
            end else begin
                wa     = r_tail;
                n_tail = ptr_inc(r_tail);
                if (ring_full) begin
                    n_head = ptr_inc(r_head);
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end
        if (emit_rdy) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
        end
    end

    // Load or drain the output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit_proc || emit_rdy) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= CENTER_RST;
            r_pos_y      <= CENTER_RST;
            r_held       <= 8'd0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_held       <= n_held;
            r_last       <= n_last;
            r_last_valid <= n_last_valid;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // Ring memory; the registered read follows the next head, with write bypass
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ring[wa] <= push_rep;
        end
        if (we && (wa == n_head)) begin
            r_head_q <= push_rep;
        end else begin
            r_head_q <= r_ring[n_head];
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (emit_proc) begin
            r_dest <= 1'b0;
            r_out  <= proc_rep;
        end else if (emit_rdy) begin
            r_dest <= 1'b1;
            r_out  <= r_head_q;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_destination = r_dest;
    assign o_out_buttons = r_out.buttons;
    assign o_abs_x       = r_out.x;
    assign o_abs_y       = r_out.y;
    assign o_out_wheel   = r_out.wheel;

endmodule

/* design/mouse_rel_to_abs_router.sv */
// Top level of the relative-to-absolute mouse report router.
//
// Input channel (i_in_valid / o_in_stall): one beat per report or event
// (report, unmount, release all, endpoint ready). Output channel
// (o_out_valid / i_out_stall): one beat per absolute report, tagged with
// its destination (peer link or local endpoint). Config channel
// (i_cfg_valid / o_cfg_ready): register index and data, always ready.
// A front end classifies beats into a two-entry command queue; the back
// end takes one command per cycle unless held by a stalled output,
// updates position and ring, and loads the output register. Throughput
// is one beat per cycle while the receiver does not stall; a result passes
// the queue and output registers. Short reports are dropped at the front.
// When the receiver stalls, the output register holds its beat and the back
// end keeps taking local reports and release events; a peer-routed report
// or unmount, or an endpoint ready, waits at the queue head, and one more
// beat behind it fills the queue and raises o_in_stall. Reset clears the
// queue, the ring pointers, the last-sent memory and loads the default
// registers, with both position registers at the default centre coordinate.
// The local ring holds RING_DEPTH reports.
module mouse_rel_to_abs_router #(
    parameter int RING_DEPTH = mrar_pkg::RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_buttons,
    input  logic signed [7:0]  i_delta_x,
    input  logic signed [7:0]  i_delta_y,
    input  logic signed [7:0]  i_wheel_delta,
    input  logic [6:0]         i_report_length,
    input  logic               i_route_local,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_destination,
    output logic [7:0]         o_out_buttons,
    output logic [15:0]        o_abs_x,
    output logic [15:0]        o_abs_y,
    output logic signed [7:0]  o_out_wheel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import mrar_pkg::*;

    t_cfg   cfg;
    t_qhead head;
    logic   pop;

    mrar_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mrar_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_buttons       (i_buttons),
        .i_delta_x       (i_delta_x),
        .i_delta_y       (i_delta_y),
        .i_wheel_delta   (i_wheel_delta),
        .i_report_length (i_report_length),
        .i_route_local   (i_route_local),
        .i_pop           (pop),
        .o_head          (head)
    );

    mrar_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_destination (o_destination),
        .o_out_buttons (o_out_buttons),
        .o_abs_x       (o_abs_x),
        .o_abs_y       (o_abs_y),
        .o_out_wheel   (o_out_wheel)
    );

endmodule
